@@ hdl/rcpu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rcpu_pkg;

  // Register file layout
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_JUMP_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd2;

  localparam int THRESH_W = 15;
  localparam int SIZE_W   = 13;

  localparam logic [THRESH_W-1:0] JUMP_THRESHOLD_RST = 15'd26214;
  localparam logic [SIZE_W-1:0]   FRAME_WIDTH_RST    = 13'd640;
  localparam logic [SIZE_W-1:0]   FRAME_HEIGHT_RST   = 13'd480;

  // Turn counts: 13-bit saturating, sum of two counts in 14 bits
  localparam int TURN_W  = 13;
  localparam int TOTAL_W = 14;

  localparam logic signed [TURN_W-1:0] TURN_MAX = 13'sd4095;
  localparam logic signed [TURN_W-1:0] TURN_MIN = -13'sd4096;

  typedef struct packed {
    logic [THRESH_W-1:0] jump_threshold;
    logic [SIZE_W-1:0]   frame_width;
    logic [SIZE_W-1:0]   frame_height;
  } rcpu_cfg_t;

  // Take one turn off on a positive jump, add one on a negative jump; saturate.
  function automatic logic signed [TURN_W-1:0] adjust_turns(
    input logic signed [TURN_W-1:0] turns,
    input logic                     jump_up,
    input logic                     jump_down
  );
    logic signed [TURN_W-1:0] res;
    res = turns;
    if (jump_up) begin
      if (turns != TURN_MIN) res = turns - TURN_W'(1);
    end else if (jump_down) begin
      if (turns != TURN_MAX) res = turns + TURN_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rcpu_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface rcpu_in_if
  import rcpu_pkg::*;
#(
  parameter int PHASE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [PHASE_BITS-1:0] wrapped_phase;

  modport source (output valid, output wrapped_phase, input ready);
  modport sink   (input valid, input wrapped_phase, output ready);
endinterface

interface rcpu_out_if
  import rcpu_pkg::*;
#(
  parameter int PHASE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [PHASE_BITS-1:0] phase_out;
  logic signed [TOTAL_W-1:0]    whole_turns;
  logic                         end_of_frame;

  modport source (output valid, output phase_out, output whole_turns, output end_of_frame,
                  input ready);
  modport sink   (input valid, input phase_out, input whole_turns, input end_of_frame,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/row_column_phase_unwrapper_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Row/column phase unwrapper. Wrapped phase words (2^PHASE_BITS = one turn)
// arrive in raster order; each yields one result word carrying the phase
// unchanged, the signed whole-turn correction (row count plus column count,
// each saturating at -4096..4095) and an end-of-frame flag. The block takes
// one word per clock while the output is not held back. A result word is
// registered in the input stage and then in the output register. This
// depth is set by the line buffer: one dual-port memory of MAX_WIDTH
// entries, read once when a word is accepted and written once when its
// result is registered; the last write is kept in a bypass register
// so that narrow frames (down to one column) still run at full rate. The
// line buffer is not cleared: the first row of each frame writes every
// column before its contents are used. Program jump_threshold,
// frame_width and frame_height over the APB port only while the block is
// idle; sizes of 0 act as 1 and sizes above MAX_WIDTH / MAX_HEIGHT saturate.

module row_column_phase_unwrapper_core
  import rcpu_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int PHASE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rcpu_in_if.sink                    in_ch,
  rcpu_out_if.source                 out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output      logic [CFG_DATA_W-1:0] prdata,
  output      logic                  pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int ENT_W = PHASE_BITS + TURN_W;

  rcpu_cfg_t cfg;

  rcpu_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------
  // Pipeline handshake: input stage -> work stage -> output register
  // ---------------------------------------------------------------------
  logic s1_v_r;
  logic out_v_r;
  logic out_free;
  logic s1_adv;
  logic accept;

  assign out_free    = !out_v_r || out_ch.ready;
  assign s1_adv      = s1_v_r && out_free;
  assign in_ch.ready = !s1_v_r || out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------------
  // Raster position and frame limits
  // ---------------------------------------------------------------------
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [31:0]      width_eff;
  logic [31:0]      height_eff;
  logic             s0_last_col;
  logic             s0_last_row;

  always_comb begin
    if (cfg.frame_width == '0) begin
      width_eff = 32'd1;
    end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
      width_eff = 32'(MAX_WIDTH);
    end else begin
      width_eff = 32'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      height_eff = 32'd1;
    end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
      height_eff = 32'(MAX_HEIGHT);
    end else begin
      height_eff = 32'(cfg.frame_height);
    end
  end

  // A row (frame) ends once the position reaches or passes the last column (row).
  assign s0_last_col = (32'(col_r) + 32'd1) >= width_eff;
  assign s0_last_row = (32'(row_r) + 32'd1) >= height_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (s0_last_col) begin
        col_r <= '0;
        row_r <= s0_last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input stage registers; line buffer read issued on accept
  // ---------------------------------------------------------------------
  logic [PHASE_BITS-1:0] s1_raw_r;
  logic [COL_W-1:0]      s1_col_r;
  logic                  s1_col_nz_r;
  logic                  s1_row_nz_r;
  logic                  s1_eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_raw_r    <= PHASE_BITS'(in_ch.wrapped_phase);
      s1_col_r    <= col_r;
      s1_col_nz_r <= (col_r != '0);
      s1_row_nz_r <= (row_r != '0);
      s1_eof_r    <= s0_last_col && s0_last_row;
    end
  end

  logic [ENT_W-1:0] lb_rd_data;
  logic [ENT_W-1:0] lb_wr_data;

  rcpu_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (ENT_W)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (lb_rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (lb_wr_data)
  );

  // ---------------------------------------------------------------------
  // Work stage: wrap the two differences, step the turn counts
  // ---------------------------------------------------------------------
  logic                     wr_v_r;
  logic [COL_W-1:0]         wr_col_r;
  logic [ENT_W-1:0]         wr_data_r;
  logic [ENT_W-1:0]         upper_ent;
  logic [PHASE_BITS-1:0]    upper_phase;
  logic signed [TURN_W-1:0] upper_turns;

  logic [PHASE_BITS-1:0]    left_phase_r;
  logic signed [TURN_W-1:0] row_turns_r;

  logic signed [PHASE_BITS-1:0] diff_left;
  logic signed [PHASE_BITS-1:0] diff_up;
  logic signed [31:0]           thr_pos;
  logic signed [31:0]           thr_neg;
  logic signed [TURN_W-1:0]     row_turns_nxt;
  logic signed [TURN_W-1:0]     col_turns_nxt;
  logic signed [TOTAL_W-1:0]    total_turns;

  // Bypass the latest line-buffer write: the read for this word may have
  // been issued on the same edge that wrote its column.
  assign upper_ent   = (wr_v_r && (wr_col_r == s1_col_r)) ? wr_data_r : lb_rd_data;
  assign upper_phase = upper_ent[PHASE_BITS-1:0];
  assign upper_turns = signed'(upper_ent[PHASE_BITS +: TURN_W]);

  assign diff_left = signed'(s1_raw_r - left_phase_r);
  assign diff_up   = signed'(s1_raw_r - upper_phase);
  assign thr_pos   = signed'(32'(cfg.jump_threshold));
  assign thr_neg   = -thr_pos;

  // Exactly half a turn wraps to the most negative code, so it counts as
  // a downward step.
  always_comb begin
    if (s1_col_nz_r) begin
      row_turns_nxt = adjust_turns(row_turns_r,
                                   32'(diff_left) > thr_pos,
                                   32'(diff_left) < thr_neg);
    end else begin
      row_turns_nxt = '0;
    end
    if (s1_row_nz_r) begin
      col_turns_nxt = adjust_turns(upper_turns,
                                   32'(diff_up) > thr_pos,
                                   32'(diff_up) < thr_neg);
    end else begin
      col_turns_nxt = '0;
    end
  end

  assign total_turns = TOTAL_W'(row_turns_nxt) + TOTAL_W'(col_turns_nxt);
  assign lb_wr_data  = {col_turns_nxt, s1_raw_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_turns_r  <= '0;
      left_phase_r <= '0;
      wr_v_r       <= 1'b0;
    end else if (s1_adv) begin
      row_turns_r  <= row_turns_nxt;
      left_phase_r <= s1_raw_r;
      wr_v_r       <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      wr_col_r  <= s1_col_r;
      wr_data_r <= lb_wr_data;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: hold the result until the sink takes the word
  // ---------------------------------------------------------------------
  logic [PHASE_BITS-1:0]     phase_out_r;
  logic signed [TOTAL_W-1:0] whole_turns_r;
  logic                      eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      phase_out_r   <= s1_raw_r;
      whole_turns_r <= total_turns;
      eof_r         <= s1_eof_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.phase_out    = signed'(phase_out_r);
  assign out_ch.whole_turns  = whole_turns_r;
  assign out_ch.end_of_frame = eof_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && s0_last_col && s0_last_row |=> (col_r == '0) && (row_r == '0))
    else $error("raster position did not return to origin after last pixel");

  a_work_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r && $stable(s1_raw_r) && $stable(s1_col_r))
    else $error("work stage lost or changed a stalled word");

  a_frame_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_col_nz_r && !s1_row_nz_r |=> out_ch.whole_turns == '0)
    else $error("first pixel of frame carries a nonzero turn count");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_ch.ready)
    else $error("input stalled with an empty work stage");

endmodule

`default_nettype wire

@@ hdl/rcpu_line_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rcpu_line_buf
  import rcpu_pkg::*;
#(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 29
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [DATA_W-1:0]        rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ hdl/rcpu_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rcpu_cfg_regs
  import rcpu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output      logic [CFG_DATA_W-1:0] prdata,
  output      logic                  pready,
  output      rcpu_cfg_t             cfg
);

  rcpu_cfg_t  cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jump_threshold <= JUMP_THRESHOLD_RST;
      cfg_r.frame_width    <= FRAME_WIDTH_RST;
      cfg_r.frame_height   <= FRAME_HEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_JUMP_THRESHOLD: cfg_r.jump_threshold <= pwdata[THRESH_W-1:0];
        REG_FRAME_WIDTH:    cfg_r.frame_width    <= pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT:   cfg_r.frame_height   <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_JUMP_THRESHOLD: prdata = CFG_DATA_W'(cfg_r.jump_threshold);
      REG_FRAME_WIDTH:    prdata = CFG_DATA_W'(cfg_r.frame_width);
      REG_FRAME_HEIGHT:   prdata = CFG_DATA_W'(cfg_r.frame_height);
      default:            prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ tb/sv/row_column_phase_unwrapper_core_tb.sv @@
`timescale 1ns / 1ps

module row_column_phase_unwrapper_core_tb;
  import rcpu_pkg::*;

  localparam int MAX_W   = 4096;
  localparam int MAX_H   = 4096;
  // A result word passes the input-stage and output registers before it leaves.
  localparam int LATENCY = 2;

  typedef struct {
    logic [15:0]        phase;
    logic [TOTAL_W-1:0] turns;
    logic               eof;
  } unwrap_result_t;

  // How the words of a phase are made up.
  typedef enum int {PIX_SMOOTH, PIX_NOISE, PIX_EDGE} pixel_kind_t;

  // Mirror of the unwrapper: positions, turn counts, line buffer and the
  // result words still owed by the block, oldest first.
  class unwrap_scoreboard;
    logic [THRESH_W-1:0]      thresh;
    logic [SIZE_W-1:0]        width_reg;
    logic [SIZE_W-1:0]        height_reg;
    int unsigned              col_pos;
    int unsigned              row_pos;
    logic [15:0]              left_phase;
    logic signed [TURN_W-1:0] row_turns;
    logic [15:0]              upper_phases [MAX_W];
    logic signed [TURN_W-1:0] col_turns [MAX_W];
    unwrap_result_t           pending [$];
    int                       errors;
    int                       results_seen;

    function new();
      thresh       = JUMP_THRESHOLD_RST;
      width_reg    = FRAME_WIDTH_RST;
      height_reg   = FRAME_HEIGHT_RST;
      col_pos      = 0;
      row_pos      = 0;
      left_phase   = '0;
      row_turns    = '0;
      errors       = 0;
      results_seen = 0;
      foreach (upper_phases[i]) begin
        upper_phases[i] = '0;
        col_turns[i]    = '0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_JUMP_THRESHOLD: thresh     = val[THRESH_W-1:0];
        REG_FRAME_WIDTH:    width_reg  = val[SIZE_W-1:0];
        REG_FRAME_HEIGHT:   height_reg = val[SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    // Zero acts as one, oversize saturates.
    function int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    // Wrapped step a - b; a half-turn step reads as negative.
    function logic signed [TURN_W-1:0] step_turns(logic signed [TURN_W-1:0] t,
                                                 logic [15:0] a, logic [15:0] b);
      logic signed [15:0] d;
      int                 thr;
      d   = a - b;
      thr = int'(thresh);
      if (int'(d) > thr) begin
        if (t != TURN_MIN) t = t - 13'sd1;
      end else if (int'(d) < -thr) begin
        if (t != TURN_MAX) t = t + 13'sd1;
      end
      return t;
    endfunction

    function void note_word(logic [15:0] ph);
      int unsigned    w;
      int unsigned    h;
      int unsigned    c;
      int             total;
      unwrap_result_t r;
      logic           last_c;
      logic           last_r;
      w = eff_size(width_reg, MAX_W);
      h = eff_size(height_reg, MAX_H);
      c = col_pos;
      if (c >= MAX_W) c = 0;
      row_turns    = (c > 0) ? step_turns(row_turns, ph, left_phase) : '0;
      col_turns[c] = (row_pos > 0) ? step_turns(col_turns[c], ph, upper_phases[c]) : '0;
      upper_phases[c] = ph;
      left_phase      = ph;
      total   = int'(row_turns) + int'(col_turns[c]);
      last_c  = (c + 1 >= w);
      last_r  = (row_pos + 1 >= h);
      r.phase = ph;
      r.turns = total[TOTAL_W-1:0];
      r.eof   = last_c && last_r;
      pending.push_back(r);
      if (last_c) begin
        col_pos = 0;
        row_pos = last_r ? 0 : row_pos + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check_result(logic [15:0] ph, logic [TOTAL_W-1:0] turns, logic eof);
      unwrap_result_t e;
      results_seen++;
      if (pending.size() == 0) begin
        $error("result word with nothing pending: phase_out %0d whole_turns %0d",
               $signed(ph), $signed(turns));
        errors++;
        return;
      end
      e = pending.pop_front();
      if (ph !== e.phase) begin
        $error("phase_out: expected %0d, got %0d", $signed(e.phase), $signed(ph));
        errors++;
      end
      if (turns !== e.turns) begin
        $error("whole_turns: expected %0d, got %0d", $signed(e.turns), $signed(turns));
        errors++;
      end
      if (eof !== e.eof) begin
        $error("end_of_frame: expected %0b, got %0b", e.eof, eof);
        errors++;
      end
    endfunction

    // Words still needed to close the current frame.
    function int unsigned words_to_frame_end();
      int unsigned w;
      int unsigned h;
      int unsigned n;
      w = eff_size(width_reg, MAX_W);
      h = eff_size(height_reg, MAX_H);
      if (col_pos == 0 && row_pos == 0) return 0;
      n = (col_pos + 1 >= w) ? 1 : w - col_pos;
      if (row_pos + 1 < h) n += (h - row_pos - 1) * w;
      return n;
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  rcpu_in_if  #(.PHASE_BITS(16)) in_if ();
  rcpu_out_if #(.PHASE_BITS(16)) out_if ();

  row_column_phase_unwrapper_core #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .PHASE_BITS(16)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  unwrap_scoreboard sb;

  // Pixel generator state for the current phase.
  int          base;
  int          grad_x;
  int          grad_y;
  int          noise_amp;
  bit          burst;
  logic [15:0] last_sent;
  int unsigned words_sent;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs a handshake.
  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Sample both handshakes at the rising edge; the input word is noted
  // before any result of the same edge is checked.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1)
        sb.note_word(in_if.wrapped_phase);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_result(out_if.phase_out, out_if.whole_turns, out_if.end_of_frame);
    end
  end

  // Stall lengths: mostly short, now and then long.
  function automatic int pick_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_gap();
    if (burst) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    return pick_len();
  endfunction

  // Result side: random back-pressure in stretches, free-running stretches,
  // and one long hold-off so the block fills and stalls its input.
  initial begin
    int stall;
    int stretch;
    bit free_run;
    bit held;
    out_if.ready = 1'b0;
    stall    = 0;
    stretch  = 0;
    free_run = 0;
    held     = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && sb.results_seen >= 200 && in_if.valid === 1'b1) begin
        held = 1;
        out_if.ready <= 1'b0;
        repeat (80) @(negedge clk);
      end else begin
        if (stretch == 0) begin
          free_run = ($urandom_range(0, 3) == 0);
          stretch  = $urandom_range(50, 200);
        end
        stretch--;
        if (stall > 0) stall--;
        else if (!free_run && $urandom_range(0, 3) == 0) stall = pick_len();
        out_if.ready <= (stall == 0);
      end
    end
  end

  // Offer one word after a random gap; hold it until taken.
  task automatic send_word(input logic [15:0] w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.wrapped_phase <= w;
    last_sent = w;
    words_sent++;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic drop_valid();
    in_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Read a register back and compare with what it should hold.
  task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (got !== want) begin
      $error("register %0d readback: expected %0d, got %0d", idx, want, got);
      sb.errors++;
    end
  endtask

  // Reprogram only once the pipe has drained and then settled.
  task automatic configure(input int unsigned thr, input int unsigned w, input int unsigned h);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
    apb_write(REG_JUMP_THRESHOLD, 32'(thr));
    apb_write(REG_FRAME_WIDTH, 32'(w));
    apb_write(REG_FRAME_HEIGHT, 32'(h));
    check_reg(REG_JUMP_THRESHOLD, 32'(thr) & 32'h7FFF);
    check_reg(REG_FRAME_WIDTH, 32'(w) & 32'h1FFF);
    check_reg(REG_FRAME_HEIGHT, 32'(h) & 32'h1FFF);
  endtask

  // Smooth: a tilted plane with light noise, wrapping on its own.
  // Edge: steps that land right on and right past the threshold, half a turn, or a random word.
  function automatic logic [15:0] make_pixel(pixel_kind_t k, int c, int r);
    int v;
    int t;
    t = int'(sb.thresh);
    case (k)
      PIX_SMOOTH: begin
        v = base + grad_x * c + grad_y * r;
        if (noise_amp > 0) v += int'($urandom_range(0, 2 * noise_amp)) - noise_amp;
      end
      PIX_EDGE: begin
        case ($urandom_range(0, 5))
          0: v = int'(last_sent) + t;
          1: v = int'(last_sent) + t + 1;
          2: v = int'(last_sent) - t;
          3: v = int'(last_sent) - t - 1;
          4: v = int'(last_sent) + 32768;
          default: v = int'($urandom);
        endcase
      end
      default: v = int'($urandom);
    endcase
    return v[15:0];
  endfunction

  function automatic void pick_content(pixel_kind_t k);
    base      = $urandom;
    grad_x    = int'($urandom_range(0, 60000)) - 30000;
    grad_y    = int'($urandom_range(0, 60000)) - 30000;
    noise_amp = (k == PIX_SMOOTH) ? $urandom_range(0, 600) : 0;
    burst     = ($urandom_range(0, 3) == 0);
  endfunction

  // Whole frames only, so the line buffer is always written before its contents are used.
  task automatic run_frames(input pixel_kind_t k, input int nframes);
    int unsigned ww;
    int unsigned hh;
    ww = sb.eff_size(sb.width_reg, MAX_W);
    hh = sb.eff_size(sb.height_reg, MAX_H);
    for (int f = 0; f < nframes; f++)
      for (int r = 0; r < int'(hh); r++)
        for (int c = 0; c < int'(ww); c++)
          send_word(make_pixel(k, c, r));
    drop_valid();
  endtask

  initial begin
    logic [15:0] dir_words [$];
    int unsigned thr;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int          frames;
    int          start_count;
    int          waited;
    pixel_kind_t k;

    in_if.valid         = 1'b0;
    in_if.wrapped_phase = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rst_n      = 1'b0;
    burst      = 0;
    last_sent  = '0;
    words_sent = 0;
    sb = new();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers come out of reset at their defaults.
    check_reg(REG_JUMP_THRESHOLD, 32'(JUMP_THRESHOLD_RST));
    check_reg(REG_FRAME_WIDTH, 32'(FRAME_WIDTH_RST));
    check_reg(REG_FRAME_HEIGHT, 32'(FRAME_HEIGHT_RST));

    // Directed: 4x3 frame at the default threshold. Steps exactly at the
    // threshold, one past it, half a turn, and the phase extremes.
    configure(26214, 4, 3);
    dir_words = '{16'h0000, 16'h6666, 16'hCCCD, 16'h8000,
                  16'h7FFF, 16'hFFFF, 16'h9998, 16'h8000,
                  16'h8000, 16'h0001, 16'h6667, 16'hFFFF};
    foreach (dir_words[i]) send_word(dir_words[i]);
    drop_valid();

    // Zero threshold, zero sizes: every word is a one-pixel frame.
    configure(0, 0, 0);
    dir_words = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000};
    foreach (dir_words[i]) send_word(dir_words[i]);
    drop_valid();

    // Largest threshold: only a half-turn step counts.
    configure(32767, 3, 2);
    dir_words = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};
    foreach (dir_words[i]) send_word(dir_words[i]);
    drop_valid();

    // Stop mid-frame, shrink the frame, then close it out: the row ends
    // past the new last column.
    configure(20000, 12, 5);
    pick_content(PIX_SMOOTH);
    for (int i = 0; i < 30; i++) send_word(make_pixel(PIX_SMOOTH, i % 12, i / 12));
    drop_valid();
    configure(20000, 4, 4);
    n = sb.words_to_frame_end();
    for (int i = 0; i < int'(n); i++) send_word(make_pixel(PIX_NOISE, 0, 0));
    drop_valid();

    // Oversize width saturates; a steady ramp walks the row count down,
    // then a narrower width closes the row past its new last column.
    configure(0, 8191, 1);
    pick_content(PIX_SMOOTH);
    base      = 0;
    grad_x    = 20000;
    grad_y    = 0;
    noise_amp = 0;
    for (int i = 0; i < 40; i++) send_word(make_pixel(PIX_SMOOTH, i, 0));
    drop_valid();
    configure(0, 4, 1);
    n = sb.words_to_frame_end();
    for (int i = 0; i < int'(n); i++) send_word(make_pixel(PIX_SMOOTH, 40 + i, 0));
    drop_valid();

    // The same down a single column with oversize height; here the ramp walks the column count up.
    configure(0, 1, 8191);
    pick_content(PIX_SMOOTH);
    base      = 0;
    grad_x    = 0;
    grad_y    = -20000;
    noise_amp = 0;
    for (int i = 0; i < 40; i++) send_word(make_pixel(PIX_SMOOTH, 0, i));
    drop_valid();
    configure(0, 1, 4);
    n = sb.words_to_frame_end();
    for (int i = 0; i < int'(n); i++) send_word(make_pixel(PIX_SMOOTH, 0, 40 + i));
    drop_valid();

    // Random phases: mostly small frames of smooth content, some noise and
    // threshold-edge steps, at varied and extreme settings.
    start_count = words_sent;
    while (words_sent - start_count < 700) begin
      case ($urandom_range(0, 9))
        0:       thr = 0;
        1:       thr = 32767;
        default: thr = $urandom_range(0, 32767);
      endcase
      case ($urandom_range(0, 9))
        0:       w = 0;
        1:       w = $urandom_range(100, 300);
        2, 3:    w = $urandom_range(17, 64);
        default: w = $urandom_range(1, 16);
      endcase
      h      = $urandom_range(0, 6);
      frames = $urandom_range(1, 3);
      if (w > 64) begin
        h      = $urandom_range(1, 2);
        frames = 1;
      end
      case ($urandom_range(0, 9))
        0, 1:    k = PIX_NOISE;
        2, 3:    k = PIX_EDGE;
        default: k = PIX_SMOOTH;
      endcase
      configure(thr, w, h);
      pick_content(k);
      run_frames(k, frames);
    end

    // Drain, then let the pipe settle before judging.
    waited = 0;
    while (sb.pending.size() != 0 && waited < 10000) begin
      @(negedge clk);
      waited++;
    end
    if (sb.pending.size() != 0) begin
      $error("%0d result words never arrived", sb.pending.size());
      sb.errors++;
    end
    repeat (LATENCY + 8) @(negedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rcpu_pkg.sv
hdl/rcpu_if.sv
hdl/rcpu_line_buf.sv
hdl/rcpu_cfg_regs.sv
hdl/row_column_phase_unwrapper_core.sv
tb/sv/row_column_phase_unwrapper_core_tb.sv
